// ----- design/lspi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspi_pkg
// Shared widths, codes and types for the level sequence parent indexer.
// ----------------------------------------------------------------------------
package lspi_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_NODES_DEF = 65536;
  localparam int MAX_DEPTH_DEF = 256;

  // Only the low LEVEL_BITS bits of an incoming level are significant.
  localparam int LEVEL_BITS = 8;

  // Field widths.
  localparam int LEVEL_W = 8;
  localparam int IDX_W   = 16;
  localparam int REL_W   = 8;
  localparam int PAR_W   = 17;
  localparam int ERR_W   = 2;
  localparam int CNT_W   = 17;

  // Node counter never goes above 65536.
  localparam int NODE_CAP = 65536;

  localparam logic [LEVEL_W-1:0] LEVEL_MASK =
    (LEVEL_BITS >= LEVEL_W) ? {LEVEL_W{1'b1}} : LEVEL_W'((1 << LEVEL_BITS) - 1);

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DEEP     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd3;

  // Where the parent of an item comes from once its stack read returns.
  typedef enum logic [1:0] {
    PSEL_ROOT,
    PSEL_DIRECT,
    PSEL_MEM
  } psel_t;

  // Item in flight between the stack controller and the result stage.
  typedef struct packed {
    logic [IDX_W-1:0] node_index;
    logic [REL_W-1:0] rel_level;
    logic [ERR_W-1:0] error;
    psel_t            psel;
    logic [IDX_W-1:0] pdirect;
  } s1_t;

endpackage

// ----- design/lspi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lspi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lspi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/lspi_stack_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lspi_stack_ctrl
// Stack pointer, level and node counter state; issues stack pushes and reads.
// ----------------------------------------------------------------------------
module lspi_stack_ctrl #(
  parameter int MAX_NODES = lspi_pkg::MAX_NODES_DEF,
  parameter int MAX_DEPTH = lspi_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic [lspi_pkg::LEVEL_W-1:0]      level,
  input  wire logic                              first,
  output lspi_pkg::s1_t                          s1,
  output logic                                   ram_we,
  output logic [$clog2(MAX_DEPTH)-1:0]           ram_waddr,
  output logic [lspi_pkg::IDX_W-1:0]             ram_wdata,
  output logic                                   ram_re,
  output logic [$clog2(MAX_DEPTH)-1:0]           ram_raddr
);

  localparam int SPW = $clog2(MAX_DEPTH + 1);
  localparam int AW  = $clog2(MAX_DEPTH);
  localparam int CW  = (SPW > lspi_pkg::LEVEL_W) ? SPW : lspi_pkg::LEVEL_W;
  localparam logic [lspi_pkg::CNT_W-1:0] NODE_LIMIT =
    lspi_pkg::CNT_W'((MAX_NODES < lspi_pkg::NODE_CAP) ? MAX_NODES : lspi_pkg::NODE_CAP);
  localparam logic [SPW-1:0] DEPTH_FULL = SPW'(MAX_DEPTH);

  logic [SPW-1:0]                 sp_r, sp_nxt;
  logic [lspi_pkg::LEVEL_W-1:0]   prev_r, prev_nxt;
  logic [lspi_pkg::LEVEL_W-1:0]   root_r, root_nxt;
  logic [lspi_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [lspi_pkg::LEVEL_W-1:0]   lv;
  logic [lspi_pkg::LEVEL_W-1:0]   climb;
  logic [lspi_pkg::IDX_W-1:0]     idx;
  logic [SPW-1:0]                 sp_top;
  logic                           push;
  logic [lspi_pkg::ERR_W-1:0]     err;

  assign lv    = level & lspi_pkg::LEVEL_MASK;
  assign idx   = cnt_r[lspi_pkg::IDX_W-1:0];
  assign climb = prev_r - lv;

  // Stack update and result fields for the item at the input.
  always_comb begin
    sp_nxt   = sp_r;
    prev_nxt = prev_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    sp_top   = sp_r;
    push     = 1'b0;
    err      = lspi_pkg::ERR_OK;
    s1       = '0;
    if (first || (cnt_r == '0)) begin
      // Start of a sequence: empty stack, new root depth.
      sp_nxt      = '0;
      root_nxt    = lv;
      prev_nxt    = lv;
      cnt_nxt     = lspi_pkg::CNT_W'(1);
      s1.psel     = lspi_pkg::PSEL_ROOT;
    end else begin
      if (cnt_r >= NODE_LIMIT) begin
        // Node limit reached: report against the current top, no state change.
        err           = lspi_pkg::ERR_OVERFLOW;
        s1.node_index = lspi_pkg::IDX_W'(NODE_LIMIT - 1'b1);
      end else begin
        s1.node_index = idx;
        prev_nxt      = lv;
        cnt_nxt       = cnt_r + 1'b1;
        if (lv > prev_r) begin
          if ((lv - prev_r) > lspi_pkg::LEVEL_W'(1)) begin
            err = lspi_pkg::ERR_DEEP;
          end
          if (sp_r < DEPTH_FULL) begin
            push   = 1'b1;
            sp_nxt = sp_r + 1'b1;
          end else begin
            err = lspi_pkg::ERR_OVERFLOW;
          end
        end else if (lv < prev_r) begin
          if (CW'(climb) > CW'(sp_r)) begin
            sp_nxt = '0;
            err    = lspi_pkg::ERR_UNDER;
          end else begin
            sp_nxt = sp_r - SPW'(climb);
          end
        end
        sp_top = sp_nxt;
      end
      // A level below the root depth.
      if (lv < root_r) begin
        s1.rel_level = '0;
        if (err < lspi_pkg::ERR_UNDER) begin
          err = lspi_pkg::ERR_UNDER;
        end
      end else begin
        s1.rel_level = lv - root_r;
      end
      s1.error = err;
      // The item just pushed is the parent, given directly; an empty stack gives the root; otherwise read the top.
      if (push) begin
        s1.psel    = lspi_pkg::PSEL_DIRECT;
        s1.pdirect = idx - 1'b1;
      end else if (sp_top == '0) begin
        s1.psel    = lspi_pkg::PSEL_ROOT;
      end else begin
        s1.psel    = lspi_pkg::PSEL_MEM;
      end
    end
  end

  // Stack memory requests.
  always_comb begin
    ram_we    = accept && push;
    ram_waddr = sp_r[AW-1:0];
    ram_wdata = idx - 1'b1;
    ram_re    = accept;
    ram_raddr = AW'(sp_top - 1'b1);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      prev_r <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (accept) begin
      sp_r   <= sp_nxt;
      prev_r <= prev_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The pointer never runs past the stack depth.
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= DEPTH_FULL)
    else $error("stack pointer beyond stack depth");

  // The node counter never runs past the node limit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NODE_LIMIT)
    else $error("node counter beyond node limit");

  // A first item restarts the stack and the counter.
  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && first) |=> (sp_r == '0) && (cnt_r == lspi_pkg::CNT_W'(1)))
    else $error("first item did not restart the sequence");

  // A push always writes at the old top and raises the pointer by one.
  a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (sp_r == $past(sp_r) + 1'b1))
    else $error("push did not advance the stack pointer");
`endif

endmodule
`default_nettype wire

// ----- design/lspi_result.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lspi_result
// Holds an item while its stack read returns, then forms the output item.
// ----------------------------------------------------------------------------
module lspi_result (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire lspi_pkg::s1_t                 s1_in,
  input  wire logic [lspi_pkg::IDX_W-1:0]    rdata,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lspi_pkg::IDX_W-1:0]         out_node_index,
  output logic [lspi_pkg::REL_W-1:0]         out_rel_level,
  output logic [lspi_pkg::PAR_W-1:0]         out_parent,
  output logic [lspi_pkg::ERR_W-1:0]         out_error
);

  logic                         s1_valid_r, s1_valid_nxt;
  lspi_pkg::s1_t                s1_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [lspi_pkg::IDX_W-1:0]   node_index_r;
  logic [lspi_pkg::REL_W-1:0]   rel_level_r;
  logic [lspi_pkg::PAR_W-1:0]   parent_r, parent_nxt;
  logic [lspi_pkg::ERR_W-1:0]   error_r;
  logic                         s1_adv;
  logic                         load_out;

  // The held item moves on whenever the output register is free or drains.
  assign s1_adv   = !out_valid_r || out_ready;
  assign load_out = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;

  // Parent selection once the stack read data is present.
  always_comb begin
    case (s1_r.psel)
      lspi_pkg::PSEL_DIRECT: parent_nxt = {1'b0, s1_r.pdirect};
      lspi_pkg::PSEL_MEM:    parent_nxt = {1'b0, rdata};
      default:               parent_nxt = {lspi_pkg::PAR_W{1'b1}};
    endcase
  end

  // Valid flags of the two stages.
  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_in;
    end
    if (load_out) begin
      node_index_r <= s1_r.node_index;
      rel_level_r  <= s1_r.rel_level;
      parent_r     <= parent_nxt;
      error_r      <= s1_r.error;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_index = node_index_r;
  assign out_rel_level  = rel_level_r;
  assign out_parent     = parent_r;
  assign out_error      = error_r;

`ifndef NO_ASSERTIONS
  // With both stages full and the output stalled, no new item may enter.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  // Every accepted item reaches the held stage on the next cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item lost before the held stage");

  // A root parent is always reported with an all-ones parent field.
  a_root_parent: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (s1_r.psel == lspi_pkg::PSEL_ROOT)) |=>
      (out_parent == {lspi_pkg::PAR_W{1'b1}}))
    else $error("root item without all-ones parent");
`endif

endmodule
`default_nettype wire

// ----- design/level_sequence_parent_indexer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// level_sequence_parent_indexer
// Turns a preorder stream of node depths into node index, relative depth,
// parent index and error code, using an ancestor stack held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per node: in_tdata carries the depth,
//   in_tuser marks the first node of a sequence. The output channel gives one
//   item per input item, in the same order.
//   An accepted input item waits in the held stage for its ancestor stack read,
//   then moves to the output register, where its output item becomes valid.
//   Throughput is one item per cycle while out_tready is high; the stack RAM
//   takes one push and one read per cycle; the pointer update is one subtract.
//   When the receiver stalls, the held stage and the output register fill and
//   in_tready drops after at most two further items; nothing is lost.
//   After reset the stack is empty and the node counter is zero, so the next
//   item starts a sequence whatever its first flag. The stack RAM needs no
//   clearing: only entries below the pointer are ever used.
// ----------------------------------------------------------------------------
module level_sequence_parent_indexer #(
  parameter int MAX_NODES = lspi_pkg::MAX_NODES_DEF,
  parameter int MAX_DEPTH = lspi_pkg::MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] level
  input  wire logic        in_tuser,   // [0] first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [15:0] node_index, [23:16] rel_level,
                                       // [40:24] parent, [42:41] error, rest 0
);

  localparam int AW = $clog2(MAX_DEPTH);

  logic                         accept;
  lspi_pkg::s1_t                s1;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [lspi_pkg::IDX_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [lspi_pkg::IDX_W-1:0]   ram_rdata;
  logic [lspi_pkg::IDX_W-1:0]   node_index;
  logic [lspi_pkg::REL_W-1:0]   rel_level;
  logic [lspi_pkg::PAR_W-1:0]   parent;
  logic [lspi_pkg::ERR_W-1:0]   error;

  assign accept = in_tvalid && in_tready;

  // Stack pointer and level state.
  lspi_stack_ctrl #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .level     (in_tdata),
    .first     (in_tuser),
    .s1        (s1),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Ancestor stack.
  lspi_ram #(
    .WIDTH (lspi_pkg::IDX_W),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Parent resolution and output register.
  lspi_result u_result (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .s1_in          (s1),
    .rdata          (ram_rdata),
    .in_ready       (in_tready),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_node_index (node_index),
    .out_rel_level  (rel_level),
    .out_parent     (parent),
    .out_error      (error)
  );

  // Output packing, highest field first.
  assign out_tdata = {5'd0, error, parent, rel_level, node_index};

endmodule
`default_nettype wire

// ----- dv/parent_index_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parent_index_checker
// Watches both channels of the level sequence parent indexer, works out the
// node index, relative depth, parent and error of every accepted item, and
// compares each output item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module parent_index_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] level
  input  wire logic        in_tuser,   // [0] first
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,  // [15:0] node_index, [23:16] rel_level,
                                       // [40:24] parent, [42:41] error
  output int               mismatch_count,
  output int               results_owed
);

  import lspi_pkg::*;

  localparam int NODE_LIMIT = (MAX_NODES_DEF < NODE_CAP) ? MAX_NODES_DEF : NODE_CAP;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic [IDX_W-1:0] node_index;
    logic [REL_W-1:0] rel_level;
    logic [PAR_W-1:0] parent;
    logic [ERR_W-1:0] error;
  } node_result_t;

  // Predicted results still owed by the block, oldest first.
  node_result_t expected_nodes[$];

  // Own copy of the ancestor stack and the sequence state.
  logic [IDX_W-1:0] ancestors [MAX_DEPTH_DEF];
  int unsigned      stack_fill;
  int unsigned      prev_depth;
  int unsigned      base_depth;
  int unsigned      node_count;
  int unsigned      results_seen;

  // Prints one line per mismatch; the log is kept short on a badly broken block.
  task automatic report_mismatch(input string field, input int unsigned wanted,
                                 input int unsigned seen);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
               $realtime, results_seen, field, wanted, seen);
    end
    mismatch_count++;
  endtask

  // Works out the result of one node and advances the stack state.
  function automatic node_result_t index_node(input logic [7:0] level_in,
                                              input logic first_in);
    node_result_t res;
    int unsigned  lv;
    int unsigned  climb;
    lv = int'(level_in & LEVEL_MASK);
    res.error = ERR_OK;

    // A new sequence empties the stack and takes this depth as its root.
    if (first_in || node_count == 0) begin
      stack_fill      = 0;
      base_depth      = lv;
      prev_depth      = lv;
      node_count      = 1;
      res.node_index  = '0;
      res.rel_level   = '0;
      res.parent      = '1;
      return res;
    end

    if (node_count >= NODE_LIMIT) begin
      // Past the node limit nothing moves; the last index is repeated.
      res.error      = ERR_OVERFLOW;
      res.node_index = IDX_W'(NODE_LIMIT - 1);
    end else begin
      res.node_index = IDX_W'(node_count);
      if (lv > prev_depth) begin
        // One step deeper pushes the previous node, whatever the size of the jump.
        if (lv - prev_depth > 1) res.error = ERR_DEEP;
        if (stack_fill < MAX_DEPTH_DEF) begin
          ancestors[stack_fill] = IDX_W'(node_count - 1);
          stack_fill++;
        end else begin
          res.error = ERR_OVERFLOW;
        end
      end else if (lv < prev_depth) begin
        // Climbing drops one entry per level, and empties the stack on underflow.
        climb = prev_depth - lv;
        if (climb > stack_fill) begin
          stack_fill = 0;
          if (res.error < ERR_UNDER) res.error = ERR_UNDER;
        end else begin
          stack_fill -= climb;
        end
      end
      prev_depth = lv;
      node_count++;
    end

    // Depth relative to the root, with anything shallower than the root flagged.
    if (lv < base_depth) begin
      if (res.error < ERR_UNDER) res.error = ERR_UNDER;
      res.rel_level = '0;
    end else begin
      res.rel_level = (lv - base_depth > 255) ? 8'hFF : REL_W'(lv - base_depth);
    end

    res.parent = (stack_fill == 0) ? '1 : {1'b0, ancestors[stack_fill - 1]};
    return res;
  endfunction

  // Output items are checked before new input items are predicted.
  always @(posedge clk) begin : watch
    node_result_t wanted;
    if (!rst_n) begin
      stack_fill = 0;
      prev_depth = 0;
      base_depth = 0;
      node_count = 0;
      expected_nodes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_nodes.size() == 0) begin
          report_mismatch("item with nothing expected", 0, out_tdata[15:0]);
        end else begin
          wanted = expected_nodes.pop_front();
          if (out_tdata[15:0] !== wanted.node_index)
            report_mismatch("node_index", wanted.node_index, out_tdata[15:0]);
          if (out_tdata[23:16] !== wanted.rel_level)
            report_mismatch("rel_level", wanted.rel_level, out_tdata[23:16]);
          if (out_tdata[40:24] !== wanted.parent)
            report_mismatch("parent", wanted.parent, out_tdata[40:24]);
          if (out_tdata[42:41] !== wanted.error)
            report_mismatch("error", wanted.error, out_tdata[42:41]);
          if (out_tdata[47:43] !== 5'd0)
            report_mismatch("padding", 0, out_tdata[47:43]);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        expected_nodes.push_back(index_node(in_tdata, in_tuser));
      end
    end
    results_owed = expected_nodes.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives preorder depth sequences into the level sequence parent indexer:
// a directed opening, a deep dive to the top depth and random walks with
// noise, with random gaps on the input side and random stalls on the output
// side.
// ----------------------------------------------------------------------------
module testbench;

  import lspi_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] level
  logic        in_tuser   = 1'b0;   // [0] first
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;           // [15:0] node_index, [23:16] rel_level,
                                    // [40:24] parent, [42:41] error
  int          mismatch_count;
  int          results_owed;
  int          items_sent;
  int          cycle_count;

  level_sequence_parent_indexer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  parent_index_checker index_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls about one cycle in nine, except for a quiet stretch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (cycle_count >= 1000 && cycle_count < 1400) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 11);
    end
  end

  // Offers one item and waits until it is taken; gaps are left out for a while.
  task automatic send_node(input logic [7:0] level, input logic first);
    while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= level;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // One sequence: a root, then steps down, level and up, with some noise.
  task automatic run_walk(input int count, input logic [7:0] root, input int noise_pct,
                          input bit noise_first);
    logic [7:0] depth;
    int         roll;
    depth = root;
    send_node(root, 1'b1);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
        depth = 8'($urandom_range(0, 255));
        send_node(depth, noise_first && ($urandom_range(0, 9) == 0));
      end else begin
        if (roll < noise_pct + 40) begin
          if (depth != 8'hFF) depth = depth + 8'd1;
        end else if (roll >= noise_pct + 65 && depth > root) begin
          depth = depth - 8'($urandom_range(1, depth - root));
        end
        send_node(depth, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] depth;
    items_sent  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: a node with no sequence started since reset, then
    // pushes, level steps, deep jumps, climbs, underflow and nodes below the root.
    send_node(8'd7,   1'b0);
    send_node(8'd8,   1'b0);
    send_node(8'd8,   1'b0);
    send_node(8'd10,  1'b0);
    send_node(8'd9,   1'b0);
    send_node(8'd7,   1'b0);
    send_node(8'd3,   1'b0);
    send_node(8'd255, 1'b0);
    send_node(8'd0,   1'b0);
    send_node(8'd255, 1'b1);
    send_node(8'd254, 1'b0);
    send_node(8'd0,   1'b1);
    send_node(8'd1,   1'b0);
    send_node(8'd2,   1'b0);
    send_node(8'd3,   1'b0);
    send_node(8'd2,   1'b0);
    send_node(8'd3,   1'b0);
    send_node(8'd1,   1'b0);
    send_node(8'd0,   1'b0);
    send_node(8'd0,   1'b0);
    send_node(8'd128, 1'b1);
    send_node(8'd129, 1'b0);
    send_node(8'd131, 1'b0);
    send_node(8'd130, 1'b0);
    send_node(8'd127, 1'b0);

    // Deep dive from depth 0 to the top depth, then climbing back in jumps.
    send_node(8'd0, 1'b1);
    for (int d = 1; d < 256; d++) send_node(8'(d), 1'b0);
    depth = 8'hFF;
    while (depth > 0) begin
      depth = depth - 8'($urandom_range(1, (depth < 20) ? depth : 20));
      send_node(depth, 1'b0);
    end

    // Random sequences: mostly well formed, some with heavy noise.
    while (items_sent < 1700) begin
      depth = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15))
                                         : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0) run_walk($urandom_range(0, 40), depth, 3, 1'b0);
      else run_walk($urandom_range(0, 30), depth, 50, 1'b1);
    end

    // A few extreme steps on the last sequence, then a fresh short sequence.
    send_node(8'd0,   1'b0);
    send_node(8'd255, 1'b0);
    send_node(8'd21,  1'b0);
    send_node(8'd5,   1'b1);
    send_node(8'd6,   1'b0);
    send_node(8'd4,   1'b0);
    in_tvalid <= 1'b0;

    // Drain the outstanding results, then allow the pipeline to settle.
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule
